>>> rtl/core/mapt_pkg.sv
// Shared types, constants and helpers of the encoder position tracker.
package mapt_pkg;

  localparam int MOTORS = 8;
  localparam int AXW    = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  localparam int PPR_W = 21;
  localparam int CNT_W = 25;
  localparam int PPD_W = 31;
  localparam int AGE_W = 32;

  localparam logic [PPR_W-1:0] PPR_RESET = PPR_W'(10000);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(131072);
  localparam logic [PPD_W-1:0] PPD_RESET = PPD_W'(1820444);
  localparam logic [AGE_W-1:0] AGE_RESET = AGE_W'(100);

  localparam int MUL_STEPS = (PPR_W + 1) / 2;
  localparam int MUL_W     = 2 * MUL_STEPS;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    REQ_UPDATE  = 2'd0,
    REQ_CAPTURE = 2'd1,
    REQ_GET     = 2'd2,
    REQ_TICK    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_MOTOR = 2'd1,
    STAT_NOT_READY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_PPR     = 2'd0,
    CFG_COUNTS  = 2'd1,
    CFG_PPD     = 2'd2,
    CFG_MAX_AGE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_CALC,
    ST_FINISH
  } top_state_t;

  typedef enum logic [2:0] {
    PU_IDLE,
    PU_PREP,
    PU_SUM,
    PU_MUL,
    PU_DIV,
    PU_SAT
  } pu_state_t;

  typedef struct packed {
    logic        fb_valid;
    logic [17:0] encoder;
    logic        turn_bit;
    logic [15:0] revs;
    logic [31:0] tick;
    logic [31:0] zero_point;
    logic        zero_valid;
  } row_t;

  typedef struct packed {
    logic           rd_en;
    logic [AXW-1:0] rd_addr;
    logic           wr_en;
    logic [AXW-1:0] wr_addr;
    row_t           wr_row;
  } mem_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/mapt_row_mem.sv
// Per-axis row memory: synchronous read, one write port, reset-cleared row valid bits.
module mapt_row_mem (
  input  logic               clk,
  input  logic               rst,
  input  mapt_pkg::mem_req_t req,
  output mapt_pkg::row_t     rd_row
);
  import mapt_pkg::*;

  row_t             rows [MOTORS];
  row_t             rd_data;
  logic [MOTORS-1:0] vld;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      rows[req.wr_addr] <= req.wr_row;
    end
    if (req.rd_en) begin
      rd_data <= rows[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr];
      end
    end
  end

  assign rd_row = rd_vld ? rd_data : '0;

endmodule

>>> rtl/core/mapt_pos_unit.sv
// Current pulse position: radix-4 serial multiply by pulses/rev, radix-4 divide by counts/rev.
module mapt_pos_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [17:0]                encoder,
  input  logic                       turn_bit,
  input  logic [15:0]                revs,
  input  logic [mapt_pkg::PPR_W-1:0] ppr,
  input  logic [mapt_pkg::CNT_W-1:0] counts,
  output logic                       done,
  output logic signed [31:0]         current
);
  import mapt_pkg::*;

  pu_state_t state, state_next;
  logic [STEP_W-1:0] cnt;

  logic ld_prep, ld_sum, mul_step, div_step, sat_step;

  logic signed [19:0] dec;
  logic signed [41:0] rc;
  logic [CNT_W-1:0]   div_d;
  logic [MUL_W-1:0]   mlt;
  logic               neg;
  logic [41:0]        mag;
  logic [63:0]        acc;
  logic [CNT_W-1:0]   rem;

  logic [1:0]         offs;
  logic [CNT_W-1:0]   cnt_eff;
  logic signed [19:0] dec_c;
  logic signed [41:0] rc_c;
  logic signed [42:0] a_c;
  logic signed [42:0] a_neg;
  logic [43:0]        pp;
  logic [63:0]        acc_mul;
  logic [CNT_W:0]     r1, r2;
  logic               q1, q2;
  logic [CNT_W-1:0]   r1b, r2b;
  logic signed [31:0] cur_c;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      PU_IDLE: if (start) state_next = PU_PREP;
      PU_PREP: state_next = PU_SUM;
      PU_SUM:  state_next = PU_MUL;
      PU_MUL:  if (cnt == STEP_W'(MUL_STEPS - 1)) state_next = PU_DIV;
      PU_DIV:  if (cnt == STEP_W'(DIV_STEPS - 1)) state_next = PU_SAT;
      PU_SAT:  state_next = PU_IDLE;
      default: state_next = PU_IDLE;
    endcase
  end

  // datapath strobes
  always_comb begin
    ld_prep  = 1'b0;
    ld_sum   = 1'b0;
    mul_step = 1'b0;
    div_step = 1'b0;
    sat_step = 1'b0;
    unique case (state)
      PU_PREP: ld_prep  = 1'b1;
      PU_SUM:  ld_sum   = 1'b1;
      PU_MUL:  mul_step = 1'b1;
      PU_DIV:  div_step = 1'b1;
      PU_SAT:  sat_step = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    offs    = {1'b0, turn_bit} + {1'b0, encoder[17]};
    cnt_eff = (counts == '0) ? CNT_W'(1) : counts;
    dec_c   = $signed({{2{encoder[17]}}, encoder}) + $signed({2'b00, offs, 16'b0});
    rc_c    = $signed(revs) * $signed({1'b0, cnt_eff});

    a_c   = $signed({rc[41], rc}) + $signed({{23{dec[19]}}, dec});
    a_neg = -a_c;

    pp      = (mlt[MUL_W-1] ? {1'b0, mag, 1'b0} : 44'd0)
            + (mlt[MUL_W-2] ? {2'b00, mag} : 44'd0);
    acc_mul = {acc[61:0], 2'b00} + {20'b0, pp};

    r1  = {rem, acc[63]};
    q1  = (r1 >= {1'b0, div_d});
    r1b = q1 ? CNT_W'(r1 - {1'b0, div_d}) : r1[CNT_W-1:0];
    r2  = {r1b, acc[62]};
    q2  = (r2 >= {1'b0, div_d});
    r2b = q2 ? CNT_W'(r2 - {1'b0, div_d}) : r2[CNT_W-1:0];

    if (neg) begin
      if ((|acc[63:32]) || (acc[31] && (|acc[30:0]))) begin
        cur_c = 32'sh8000_0000;
      end else begin
        cur_c = $signed(32'(-acc[31:0]));
      end
    end else begin
      if (|acc[63:31]) begin
        cur_c = 32'sh7FFF_FFFF;
      end else begin
        cur_c = $signed(acc[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_prep) begin
      dec   <= dec_c;
      rc    <= rc_c;
      div_d <= cnt_eff;
      mlt   <= {{(MUL_W - PPR_W){1'b0}}, ppr};
      acc   <= '0;
    end
    if (ld_sum) begin
      neg <= a_c[42];
      mag <= a_c[42] ? a_neg[41:0] : a_c[41:0];
      rem <= '0;
    end
    if (mul_step) begin
      acc <= acc_mul;
      mlt <= {mlt[MUL_W-3:0], 2'b00};
    end
    if (div_step) begin
      acc <= {acc[61:0], q1, q2};
      rem <= r2b;
    end
    if (sat_step) begin
      current <= cur_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PU_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + STEP_W'(1);
      done  <= sat_step;
    end
  end

endmodule

>>> rtl/core/multi_axis_encoder_position_tracker_top.sv
// Multi-axis encoder position tracker: request control, config registers, result logic.
//
// Requests enter on start when busy is low, carrying req_type, motor_index and the
// feedback / angle fields. Every request gives exactly one result: done is high for
// one cycle with status, pulse_error, is_fresh, zero_is_captured and update_tick.
// The receiver cannot stall; a result is simply presented for that one cycle.
// Feedback update, time tick, a request on an invalid axis, and capture or get
// pulses on an axis that is not ready go through the read and finish states to done.
// Capture zero and get pulses with valid data also pass the wait and calc states: the
// position unit runs a radix-4 multiply by pulses_per_rev and a radix-4 divide by
// encoder_counts_per_rev. One request is in flight at a time; the next may be
// accepted in the cycle in which done is high.
// Axis rows live in a small synchronous memory, read at accept and written back by
// an update or a successful capture. Reset clears all row valid bits (rows read as
// zero), the tick counter and the config registers to their defaults, with no clearing pass.
// Config writes on cfg_valid/cfg_ready (always ready) are taken at any time but must
// only be issued while the block is idle.
module multi_axis_encoder_position_tracker_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [5:0]         motor_index,
  input  logic signed [17:0] encoder_reading,
  input  logic [15:0]        turn_count,
  input  logic signed [15:0] revolutions,
  input  logic signed [25:0] angle_q16,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] pulse_error,
  output logic               is_fresh,
  output logic               zero_is_captured,
  output logic [31:0]        update_tick,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import mapt_pkg::*;

  top_state_t state, state_next;

  logic [PPR_W-1:0] ppr;
  logic [CNT_W-1:0] counts;
  logic [PPD_W-1:0] ppd;
  logic [AGE_W-1:0] max_age;
  logic [31:0]      now_tick;

  req_t               req_q;
  logic [AXW-1:0]     ax_q;
  logic               ax_ok_q;
  logic [17:0]        enc_q;
  logic               turn_q;
  logic [15:0]        revs_q;
  logic signed [25:0] angle_q;

  mem_req_t mem_req;
  row_t     rd_row;
  row_t     row_q;

  logic signed [57:0] p_prod;
  logic signed [33:0] get_hi;
  logic signed [33:0] cap_sum;

  logic               pos_start;
  logic               pos_done;
  logic signed [31:0] pos_cur;

  logic accept, rd_ld, calc_ld, fin;
  logic need_pos;

  logic signed [25:0] p_hi;
  logic               frac_nz;
  logic signed [33:0] hi_c;
  logic signed [33:0] cap_c;
  logic signed [33:0] get_fix;
  logic signed [31:0] get_sat;
  logic signed [31:0] zero_sat;
  logic               ready_get;
  logic               ready_cap;
  row_t               row_new;
  logic [31:0]        now_next;
  logic [1:0]         status_c;
  logic               wr_c;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_READ;
      ST_READ:   state_next = need_pos ? ST_WAIT : ST_FINISH;
      ST_WAIT:   if (pos_done) state_next = ST_CALC;
      ST_CALC:   state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = 1'b1;
    rd_ld     = 1'b0;
    pos_start = 1'b0;
    calc_ld   = 1'b0;
    fin       = 1'b0;
    unique case (state)
      ST_IDLE:   busy      = 1'b0;
      ST_READ: begin
        rd_ld     = 1'b1;
        pos_start = need_pos;
      end
      ST_CALC:   calc_ld   = 1'b1;
      ST_FINISH: fin       = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    need_pos = ax_ok_q && rd_row.fb_valid &&
               ((req_q == REQ_CAPTURE) || ((req_q == REQ_GET) && rd_row.zero_valid));

    p_hi    = p_prod[57:32];
    frac_nz = |p_prod[31:0];
    hi_c    = $signed({{8{p_hi[25]}}, p_hi}) - $signed({{2{pos_cur[31]}}, pos_cur})
            + $signed({{2{row_q.zero_point[31]}}, row_q.zero_point});
    cap_c   = $signed({{2{pos_cur[31]}}, pos_cur}) + $signed({{8{p_hi[25]}}, p_hi})
            + $signed({33'b0, p_prod[57] & frac_nz});

    get_fix  = get_hi + $signed({33'b0, get_hi[33] & frac_nz});
    get_sat  = sat32(get_fix);
    zero_sat = sat32(cap_sum);

    ready_cap = row_q.fb_valid;
    ready_get = row_q.fb_valid && row_q.zero_valid;

    now_next = (req_q == REQ_TICK) ? now_tick + 32'd1 : now_tick;

    row_new = row_q;
    wr_c    = 1'b0;
    if (!ax_ok_q) begin
      status_c = STAT_BAD_MOTOR;
    end else begin
      status_c = STAT_OK;
      case (req_q)
        REQ_UPDATE: begin
          row_new.fb_valid = 1'b1;
          row_new.encoder  = enc_q;
          row_new.turn_bit = turn_q;
          row_new.revs     = revs_q;
          row_new.tick     = now_tick;
          wr_c             = 1'b1;
        end
        REQ_CAPTURE: begin
          if (ready_cap) begin
            row_new.zero_point = zero_sat;
            row_new.zero_valid = 1'b1;
            wr_c               = 1'b1;
          end else begin
            status_c = STAT_NOT_READY;
          end
        end
        REQ_GET: begin
          if (!ready_get) status_c = STAT_NOT_READY;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = accept;
    mem_req.rd_addr = motor_index[AXW-1:0];
    mem_req.wr_en   = fin && wr_c;
    mem_req.wr_addr = ax_q;
    mem_req.wr_row  = row_new;
  end

  mapt_row_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .req    (mem_req),
    .rd_row (rd_row)
  );

  mapt_pos_unit u_pos (
    .clk      (clk),
    .rst      (rst),
    .start    (pos_start),
    .encoder  (row_q.encoder),
    .turn_bit (row_q.turn_bit),
    .revs     (row_q.revs),
    .ppr      (ppr),
    .counts   (counts),
    .done     (pos_done),
    .current  (pos_cur)
  );

  // request payload and work registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req_t'(req_type);
      ax_q    <= motor_index[AXW-1:0];
      ax_ok_q <= ({1'b0, motor_index} < 7'(MOTORS));
      enc_q   <= encoder_reading;
      turn_q  <= turn_count[0];
      revs_q  <= revolutions;
      angle_q <= angle_q16;
    end
    if (rd_ld) begin
      row_q  <= rd_row;
      p_prod <= angle_q * $signed({1'b0, ppd});
    end
    if (calc_ld) begin
      get_hi  <= hi_c;
      cap_sum <= cap_c;
    end
    if (fin) begin
      status           <= status_c;
      pulse_error      <= (ax_ok_q && (req_q == REQ_GET) && ready_get) ? get_sat : '0;
      is_fresh         <= ax_ok_q && row_new.fb_valid &&
                          ((now_next - row_new.tick) < max_age);
      zero_is_captured <= ax_ok_q && row_new.zero_valid;
      update_tick      <= ax_ok_q ? row_new.tick : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      now_tick <= '0;
      ppr      <= PPR_RESET;
      counts   <= CNT_RESET;
      ppd      <= PPD_RESET;
      max_age  <= AGE_RESET;
    end else begin
      state <= state_next;
      done  <= fin;
      if (fin) begin
        now_tick <= now_next;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PPR:     ppr     <= cfg_data[PPR_W-1:0];
          CFG_COUNTS:  counts  <= cfg_data[CNT_W-1:0];
          CFG_PPD:     ppd     <= cfg_data[PPD_W-1:0];
          CFG_MAX_AGE: max_age <= cfg_data[AGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result beat without a finishing request");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> (pulse_error == '0))
    else $error("nonzero pulse_error on a failed request");

  a_wr_valid_axis: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> ax_ok_q)
    else $error("row write on an invalid axis");

  a_pos_in_wait: assert property (@(posedge clk) disable iff (rst)
    pos_done |-> (state == ST_WAIT))
    else $error("position unit finished outside the wait state");

endmodule
